// File: hw/rtl/hed_pkg.sv
// ============================================================================
// hed_pkg
// Shared types, register indexes, reset values and default sizes for the
// hysteresis episode detector.
// ============================================================================
package hed_pkg;

    localparam int DEF_MAX_LAG     = 16;
    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_INDEX_BITS  = 32;

    localparam int LAG_BITS       = 5;
    localparam int COUNT_BITS     = 16;
    localparam int OUT_INDEX_BITS = 32;
    localparam int CAUSE_BITS     = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int M_TDATA_BITS   = 72;

    localparam int RST_LAG_STEPS         = 1;
    localparam int RST_UP_THRESHOLD      = 16384;
    localparam int RST_DOWN_THRESHOLD    = 8192;
    localparam int RST_DELTA_THRESHOLD   = 4096;
    localparam int RST_MIN_LENGTH        = 1;
    localparam int RST_MISSING_ALLOWANCE = 0;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LAG_STEPS         = 3'd0,
        REG_UP_THRESHOLD      = 3'd1,
        REG_DOWN_THRESHOLD    = 3'd2,
        REG_DELTA_THRESHOLD   = 3'd3,
        REG_MIN_LENGTH        = 3'd4,
        REG_MISSING_ALLOWANCE = 3'd5
    } hed_reg_index_t;

    typedef enum logic [CAUSE_BITS-1:0] {
        CAUSE_EXPLICIT = 2'd0,
        CAUSE_MISSING  = 2'd1,
        CAUSE_SEQ_END  = 2'd2
    } hed_cause_t;

endpackage

// File: hw/rtl/hed_cfg_regs.sv
// ============================================================================
// hed_cfg_regs
// Configuration register file, written through a plain write port.
// ============================================================================
module hed_cfg_regs #(
    parameter int SAMPLE_BITS = hed_pkg::DEF_SAMPLE_BITS,
    parameter int CFG_BITS    = (SAMPLE_BITS > hed_pkg::COUNT_BITS) ?
                                SAMPLE_BITS : hed_pkg::COUNT_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [hed_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [CFG_BITS-1:0]                 cfg_data,
    output logic [hed_pkg::LAG_BITS-1:0]        lag_steps,
    output logic signed [SAMPLE_BITS-1:0]       up_threshold,
    output logic signed [SAMPLE_BITS-1:0]       down_threshold,
    output logic [SAMPLE_BITS-1:0]              delta_threshold,
    output logic [hed_pkg::COUNT_BITS-1:0]      min_length,
    output logic [hed_pkg::COUNT_BITS-1:0]      missing_allowance
);

    logic [hed_pkg::LAG_BITS-1:0]   lag_reg;
    logic [SAMPLE_BITS-1:0]         up_reg;
    logic [SAMPLE_BITS-1:0]         down_reg;
    logic [SAMPLE_BITS-1:0]         delta_reg;
    logic [hed_pkg::COUNT_BITS-1:0] min_reg;
    logic [hed_pkg::COUNT_BITS-1:0] allow_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_reg   <= hed_pkg::LAG_BITS'(hed_pkg::RST_LAG_STEPS);
            up_reg    <= SAMPLE_BITS'(hed_pkg::RST_UP_THRESHOLD);
            down_reg  <= SAMPLE_BITS'(hed_pkg::RST_DOWN_THRESHOLD);
            delta_reg <= SAMPLE_BITS'(hed_pkg::RST_DELTA_THRESHOLD);
            min_reg   <= hed_pkg::COUNT_BITS'(hed_pkg::RST_MIN_LENGTH);
            allow_reg <= hed_pkg::COUNT_BITS'(hed_pkg::RST_MISSING_ALLOWANCE);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                hed_pkg::REG_LAG_STEPS:
                    lag_reg <= cfg_data[hed_pkg::LAG_BITS-1:0];
                hed_pkg::REG_UP_THRESHOLD:
                    up_reg <= cfg_data[SAMPLE_BITS-1:0];
                hed_pkg::REG_DOWN_THRESHOLD:
                    down_reg <= cfg_data[SAMPLE_BITS-1:0];
                hed_pkg::REG_DELTA_THRESHOLD:
                    delta_reg <= cfg_data[SAMPLE_BITS-1:0];
                hed_pkg::REG_MIN_LENGTH:
                    min_reg <= cfg_data[hed_pkg::COUNT_BITS-1:0];
                hed_pkg::REG_MISSING_ALLOWANCE:
                    allow_reg <= cfg_data[hed_pkg::COUNT_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign lag_steps         = lag_reg;
    assign up_threshold      = $signed(up_reg);
    assign down_threshold    = $signed(down_reg);
    assign delta_threshold   = delta_reg;
    assign min_length        = min_reg;
    assign missing_allowance = allow_reg;

endmodule

// File: hw/rtl/hed_history.sv
// ============================================================================
// hed_history
// Delay line memory for the lagged difference, with write pointer and a fill
// count that stands in for per-entry valid bits.
// ============================================================================
module hed_history #(
    parameter int MAX_LAG     = hed_pkg::DEF_MAX_LAG,
    parameter int SAMPLE_BITS = hed_pkg::DEF_SAMPLE_BITS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              accept,
    input  logic signed [SAMPLE_BITS-1:0]     sample_value,
    input  logic                              sample_present,
    input  logic                              end_of_sequence,
    input  logic [hed_pkg::LAG_BITS-1:0]      lag_steps,
    output logic signed [SAMPLE_BITS-1:0]     hist_value,
    output logic                              hist_ok
);

    localparam int PTR_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
    localparam int CNT_W = $clog2(MAX_LAG + 1);
    localparam int SUM_W = CNT_W + 2;

    logic [SAMPLE_BITS:0] mem [MAX_LAG];
    logic [SAMPLE_BITS:0] rd_data_reg;

    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             ref_ok_reg;
    logic             ref_ok_next;

    logic [CNT_W-1:0] lag_k;
    logic [SUM_W-1:0] rd_sum;
    logic [SUM_W-1:0] rd_wrap;
    logic [PTR_W-1:0] rd_addr;

    always_comb
    begin
        if (int'(lag_steps) > MAX_LAG)
        begin
            lag_k = CNT_W'(MAX_LAG);
        end
        else
        begin
            lag_k = CNT_W'(lag_steps);
        end
        rd_sum  = SUM_W'(ptr_reg) + SUM_W'(MAX_LAG) - SUM_W'(lag_k);
        rd_wrap = (rd_sum >= SUM_W'(MAX_LAG)) ? (rd_sum - SUM_W'(MAX_LAG)) : rd_sum;
        rd_addr = rd_wrap[PTR_W-1:0];
    end

    always_comb
    begin
        ptr_next    = ptr_reg;
        fill_next   = fill_reg;
        ref_ok_next = ref_ok_reg;
        if (accept)
        begin
            ref_ok_next = sample_present && (lag_k != '0) && (fill_reg >= lag_k);
            if (end_of_sequence)
            begin
                ptr_next  = '0;
                fill_next = '0;
            end
            else
            begin
                ptr_next  = (ptr_reg == PTR_W'(MAX_LAG - 1)) ? '0 : ptr_reg + 1'b1;
                fill_next = (fill_reg == CNT_W'(MAX_LAG)) ? fill_reg : fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            fill_reg   <= '0;
            ref_ok_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            fill_reg   <= fill_next;
            ref_ok_reg <= ref_ok_next;
        end
    end

    // Read and write share the cycle; a read of the entry being written
    // returns its earlier contents.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[ptr_reg] <= {sample_present, sample_value};
            rd_data_reg  <= mem[rd_addr];
        end
    end

    assign hist_value = $signed(rd_data_reg[SAMPLE_BITS-1:0]);
    assign hist_ok    = ref_ok_reg && rd_data_reg[SAMPLE_BITS];

endmodule

// File: hw/rtl/hed_episode.sv
// ============================================================================
// hed_episode
// Second pipeline stage: difference, threshold tests, episode state and the
// result register.
// ============================================================================
module hed_episode #(
    parameter int SAMPLE_BITS = hed_pkg::DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = hed_pkg::DEF_INDEX_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                accept,
    input  logic signed [SAMPLE_BITS-1:0]       sample_value,
    input  logic                                sample_present,
    input  logic                                end_of_sequence,
    input  logic signed [SAMPLE_BITS-1:0]       hist_value,
    input  logic                                hist_ok,
    input  logic signed [SAMPLE_BITS-1:0]       up_threshold,
    input  logic signed [SAMPLE_BITS-1:0]       down_threshold,
    input  logic [SAMPLE_BITS-1:0]              delta_threshold,
    input  logic [hed_pkg::COUNT_BITS-1:0]      min_length,
    input  logic [hed_pkg::COUNT_BITS-1:0]      missing_allowance,
    output logic                                in_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [hed_pkg::M_TDATA_BITS-1:0]    out_data
);

    localparam int DW    = SAMPLE_BITS + 1;
    localparam int CMP_W = (INDEX_BITS + 1 > hed_pkg::COUNT_BITS) ?
                           INDEX_BITS + 1 : hed_pkg::COUNT_BITS;
    localparam int OW    = hed_pkg::OUT_INDEX_BITS;
    localparam int PAD_W = hed_pkg::M_TDATA_BITS - 2 * OW - hed_pkg::CAUSE_BITS;

    logic                          p1_valid_reg;
    logic                          p1_valid_next;
    logic signed [SAMPLE_BITS-1:0] p1_value_reg;
    logic                          p1_present_reg;
    logic                          p1_last_reg;

    logic                          in_ep_reg;
    logic                          in_ep_next;
    logic [INDEX_BITS-1:0]         index_reg;
    logic [INDEX_BITS-1:0]         index_next;
    logic [INDEX_BITS-1:0]         start_reg;
    logic [INDEX_BITS-1:0]         start_next;
    logic [INDEX_BITS-1:0]         last_valid_reg;
    logic [INDEX_BITS-1:0]         last_valid_next;
    logic [hed_pkg::COUNT_BITS-1:0] miss_reg;
    logic [hed_pkg::COUNT_BITS-1:0] miss_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [OW-1:0]                 out_start_reg;
    logic [OW-1:0]                 out_end_reg;
    hed_pkg::hed_cause_t           out_cause_reg;

    logic                          advance;
    logic signed [DW-1:0]          diff;
    logic signed [DW-1:0]          delta_pos;
    logic signed [DW-1:0]          delta_neg;
    logic                          rise_hit;
    logic                          end_evt;
    logic                          miss_over;
    logic                          close_branch;
    logic                          open_after;
    logic [INDEX_BITS-1:0]         start_mid;
    logic [INDEX_BITS-1:0]         last_mid;
    logic [hed_pkg::COUNT_BITS-1:0] miss_mid;
    logic [INDEX_BITS-1:0]         span;
    logic [INDEX_BITS:0]           ep_len;
    logic                          long_enough;
    logic                          emit;
    hed_pkg::hed_cause_t           cause;

    assign advance  = p1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !p1_valid_reg || advance;

    always_comb
    begin
        diff      = DW'(p1_value_reg) - DW'(hist_value);
        delta_pos = $signed({1'b0, delta_threshold});
        delta_neg = DW'(0) - delta_pos;
        rise_hit  = (p1_present_reg && (p1_value_reg >= up_threshold))
                 || (hist_ok && (diff >= delta_pos));
        end_evt   = (p1_present_reg && (p1_value_reg <= down_threshold))
                 || (hist_ok && (diff <= delta_neg));
        miss_over = !p1_present_reg && (miss_reg >= missing_allowance);

        close_branch = in_ep_reg && (end_evt || miss_over);
        start_mid    = start_reg;
        last_mid     = last_valid_reg;
        miss_mid     = miss_reg;
        open_after   = in_ep_reg;
        if (!in_ep_reg)
        begin
            if (rise_hit)
            begin
                open_after = 1'b1;
                start_mid  = index_reg;
                last_mid   = index_reg;
                miss_mid   = '0;
            end
        end
        else if (end_evt || miss_over)
        begin
            open_after = 1'b0;
            miss_mid   = '0;
        end
        else if (p1_present_reg)
        begin
            last_mid = index_reg;
            miss_mid = '0;
        end
        else
        begin
            miss_mid = miss_reg + 1'b1;
        end

        span        = last_mid - start_mid;
        ep_len      = {1'b0, span} + 1'b1;
        long_enough = CMP_W'(ep_len) >= CMP_W'(min_length);
        emit        = (close_branch || (p1_last_reg && open_after)) && long_enough;
        if (close_branch)
        begin
            cause = end_evt ? hed_pkg::CAUSE_EXPLICIT : hed_pkg::CAUSE_MISSING;
        end
        else
        begin
            cause = hed_pkg::CAUSE_SEQ_END;
        end
    end

    always_comb
    begin
        p1_valid_next   = p1_valid_reg;
        in_ep_next      = in_ep_reg;
        index_next      = index_reg;
        start_next      = start_reg;
        last_valid_next = last_valid_reg;
        miss_next       = miss_reg;
        out_valid_next  = out_valid_reg;
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p1_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = emit;
            if (p1_last_reg)
            begin
                in_ep_next      = 1'b0;
                index_next      = '0;
                start_next      = '0;
                last_valid_next = '0;
                miss_next       = '0;
            end
            else
            begin
                in_ep_next      = open_after;
                index_next      = index_reg + 1'b1;
                start_next      = start_mid;
                last_valid_next = last_mid;
                miss_next       = miss_mid;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg   <= 1'b0;
            in_ep_reg      <= 1'b0;
            index_reg      <= '0;
            start_reg      <= '0;
            last_valid_reg <= '0;
            miss_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            p1_valid_reg   <= p1_valid_next;
            in_ep_reg      <= in_ep_next;
            index_reg      <= index_next;
            start_reg      <= start_next;
            last_valid_reg <= last_valid_next;
            miss_reg       <= miss_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_value_reg   <= sample_value;
            p1_present_reg <= sample_present;
            p1_last_reg    <= end_of_sequence;
        end
        if (advance && emit)
        begin
            out_start_reg <= OW'(start_mid);
            out_end_reg   <= OW'(last_mid);
            out_cause_reg <= cause;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {{PAD_W{1'b0}}, out_cause_reg, out_end_reg, out_start_reg};

endmodule

// File: hw/rtl/hysteresis_episode_detector_unit.sv
// ============================================================================
// hysteresis_episode_detector_unit
// Detects hysteresis episodes in a stream of possibly missing samples and
// emits one record per reported episode.
// ============================================================================
// The block takes one sample per clock cycle while s_tready is high and
// returns zero or one episode record per sample. m_tvalid for a record rises
// when the sample that closes the episode leaves the episode stage and the
// record is loaded into the result register. The rate is set by the delay
// line memory, which is read and written once per sample, and by the episode
// state update, which also runs once per sample. The result register lets a
// new sample in while a record waits; the slave side stalls only while a
// record is held and the next sample sits in the episode stage. After reset
// and after each end of sequence the delay line counts as empty without any
// clearing pass.
module hysteresis_episode_detector_unit #(
    parameter int MAX_LAG     = hed_pkg::DEF_MAX_LAG,
    parameter int SAMPLE_BITS = hed_pkg::DEF_SAMPLE_BITS,
    parameter int INDEX_BITS  = hed_pkg::DEF_INDEX_BITS,
    parameter int CFG_BITS    = (SAMPLE_BITS > hed_pkg::COUNT_BITS) ?
                                SAMPLE_BITS : hed_pkg::COUNT_BITS,
    parameter int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [hed_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]                cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [S_TDATA_BITS-1:0]            s_tdata,   // sample_value
    input  logic                               s_tuser,   // sample_present
    input  logic                               s_tlast,   // end_of_sequence
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hed_pkg::M_TDATA_BITS-1:0]   m_tdata    // episode_start, episode_end,
                                                          // end_cause, zero fill
);

    logic                              accept;
    logic signed [SAMPLE_BITS-1:0]     sample_value;
    logic [hed_pkg::LAG_BITS-1:0]      lag_steps;
    logic signed [SAMPLE_BITS-1:0]     up_threshold;
    logic signed [SAMPLE_BITS-1:0]     down_threshold;
    logic [SAMPLE_BITS-1:0]            delta_threshold;
    logic [hed_pkg::COUNT_BITS-1:0]    min_length;
    logic [hed_pkg::COUNT_BITS-1:0]    missing_allowance;
    logic signed [SAMPLE_BITS-1:0]     hist_value;
    logic                              hist_ok;

    assign accept       = s_tvalid && s_tready;
    assign sample_value = $signed(s_tdata[SAMPLE_BITS-1:0]);

    hed_cfg_regs #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_cfg (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .lag_steps         (lag_steps),
        .up_threshold      (up_threshold),
        .down_threshold    (down_threshold),
        .delta_threshold   (delta_threshold),
        .min_length        (min_length),
        .missing_allowance (missing_allowance)
    );

    hed_history #(
        .MAX_LAG     (MAX_LAG),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_history (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .sample_value    (sample_value),
        .sample_present  (s_tuser),
        .end_of_sequence (s_tlast),
        .lag_steps       (lag_steps),
        .hist_value      (hist_value),
        .hist_ok         (hist_ok)
    );

    hed_episode #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_episode (
        .clk               (clk),
        .rst_n             (rst_n),
        .accept            (accept),
        .sample_value      (sample_value),
        .sample_present    (s_tuser),
        .end_of_sequence   (s_tlast),
        .hist_value        (hist_value),
        .hist_ok           (hist_ok),
        .up_threshold      (up_threshold),
        .down_threshold    (down_threshold),
        .delta_threshold   (delta_threshold),
        .min_length        (min_length),
        .missing_allowance (missing_allowance),
        .in_ready          (s_tready),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_data          (m_tdata)
    );

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Randomized stream test for the hysteresis episode detector.
// ============================================================================
// Samples go in over the slave stream. Episode records come out over the
// master stream. Both sides stall at random but for one phase without gaps.
// A predictor in this file follows every accepted sample and queues the
// record that the sample must produce. Each record that comes out is compared
// with the oldest queued one. The run goes through a directed list and then
// several register settings, the extreme ones among them.
// ============================================================================
module tb_top;

    import hed_pkg::*;

    localparam int GAP_PCT      = 16;
    localparam int HIST_DEPTH   = DEF_MAX_LAG;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 153;
    localparam int SETTLE_CYC   = 6;
    localparam int DRAIN_LIMIT  = 2000;
    localparam int TIMEOUT_NS   = 3_000_000;

    typedef struct {
        logic signed [15:0] value;
        bit                 present;
        bit                 last;
    } sample_t;

    typedef struct packed {
        hed_cause_t  cause;
        logic [31:0] ep_end;
        logic [31:0] ep_start;
    } episode_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      cfg_wr_en  = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
    logic [15:0]               cfg_data   = '0;
    logic                      s_tvalid   = 1'b0;
    logic                      s_tready;
    logic [15:0]               s_tdata    = '0;  // sample_value
    logic                      s_tuser    = 1'b0; // sample_present
    logic                      s_tlast    = 1'b0; // end_of_sequence
    logic                      m_tvalid;
    logic                      m_tready   = 1'b0;
    logic [M_TDATA_BITS-1:0]   m_tdata;    // episode_start, episode_end, end_cause, zero fill

    sample_t  sample_q[$];
    episode_t episode_q[$];
    sample_t  in_flight;
    bit       no_gaps = 1'b0;

    int mismatch_count  = 0;
    int samples_sent    = 0;
    int records_checked = 0;
    int settings_used   = 1;
    int cause_count[3]  = '{0, 0, 0};

    logic [4:0]         lag_reg;
    logic signed [15:0] up_reg;
    logic signed [15:0] down_reg;
    logic [15:0]        delta_reg;
    logic [15:0]        min_len_reg;
    logic [15:0]        allow_reg;

    logic signed [15:0] hist_value[HIST_DEPTH];
    bit                 hist_valid[HIST_DEPTH];
    int                 hist_wr;
    logic [31:0]        seq_index;
    bit                 episode_open;
    logic [31:0]        open_start;
    logic [31:0]        open_last_valid;
    logic [15:0]        miss_run;

    hysteresis_episode_detector_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void clear_sequence();
        for (int n = 0; n < HIST_DEPTH; n++)
        begin
            hist_value[n] = '0;
            hist_valid[n] = 1'b0;
        end
        hist_wr         = 0;
        seq_index       = '0;
        episode_open    = 1'b0;
        open_start      = '0;
        open_last_valid = '0;
        miss_run        = '0;
    endfunction

    function automatic void close_episode(hed_cause_t cause);
        logic [32:0] len;
        episode_t    rec;
        len          = {1'b0, open_last_valid - open_start} + 33'd1;
        episode_open = 1'b0;
        miss_run     = '0;
        if (len >= {17'd0, min_len_reg})
        begin
            rec.cause    = cause;
            rec.ep_start = open_start;
            rec.ep_end   = open_last_valid;
            episode_q.push_back(rec);
        end
    endfunction

    function automatic void track_sample(sample_t s);
        int lag;
        int pos;
        int diff;
        bit have_diff;
        bit rise;
        bit fall;
        lag       = (lag_reg > HIST_DEPTH) ? HIST_DEPTH : int'(lag_reg);
        have_diff = 1'b0;
        diff      = 0;
        if (lag >= 1 && s.present)
        begin
            pos = (hist_wr + HIST_DEPTH - lag) % HIST_DEPTH;
            if (hist_valid[pos])
            begin
                have_diff = 1'b1;
                diff      = int'(s.value) - int'(hist_value[pos]);
            end
        end
        hist_value[hist_wr] = s.present ? s.value : 16'sd0;
        hist_valid[hist_wr] = s.present;
        hist_wr             = (hist_wr + 1) % HIST_DEPTH;

        rise = (s.present && s.value >= up_reg) || (have_diff && diff >= int'(delta_reg));
        fall = (s.present && s.value <= down_reg) || (have_diff && diff <= -int'(delta_reg));

        if (!episode_open)
        begin
            if (rise)
            begin
                episode_open    = 1'b1;
                open_start      = seq_index;
                open_last_valid = seq_index;
                miss_run        = '0;
            end
        end
        else if (fall)
            close_episode(CAUSE_EXPLICIT);
        else if (s.present)
        begin
            open_last_valid = seq_index;
            miss_run        = '0;
        end
        else if (miss_run >= allow_reg)
            close_episode(CAUSE_MISSING);
        else
            miss_run = miss_run + 16'd1;

        if (s.last)
        begin
            if (episode_open)
                close_episode(CAUSE_SEQ_END);
            clear_sequence();
        end
        else
            seq_index = seq_index + 32'd1;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                track_sample(in_flight);
                samples_sent++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (sample_q.size() > 0 && (no_gaps || $urandom_range(99) >= GAP_PCT))
                begin
                    in_flight = sample_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= in_flight.value;
                    s_tuser  <= in_flight.present;
                    s_tlast  <= in_flight.last;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_record(input logic [M_TDATA_BITS-1:0] got);
        episode_t                rec;
        logic [M_TDATA_BITS-1:0] want;
        if (episode_q.size() == 0)
        begin
            $display("%0t: unexpected record start=%0d end=%0d cause=%0d",
                     $time, got[31:0], got[63:32], got[65:64]);
            mismatch_count++;
        end
        else
        begin
            rec  = episode_q.pop_front();
            want = {{(M_TDATA_BITS - $bits(episode_t)){1'b0}}, rec};
            records_checked++;
            cause_count[int'(rec.cause)]++;
            if (got !== want)
            begin
                $display("%0t: record mismatch expected start=%0d end=%0d cause=%0d fill=0",
                         $time, rec.ep_start, rec.ep_end, rec.cause);
                $display("%0t:                 actual   start=%0d end=%0d cause=%0d fill=%0h",
                         $time, got[31:0], got[63:32], got[65:64],
                         got[M_TDATA_BITS-1:$bits(episode_t)]);
                mismatch_count++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_record(m_tdata);
            m_tready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
        end
    end

    task automatic push_sample(input logic signed [15:0] value, input bit present,
                               input bit last);
        sample_t s;
        s.value   = value;
        s.present = present;
        s.last    = last;
        sample_q.push_back(s);
    endtask

    task automatic add_sequence(input int len, input int miss_pct);
        int level;
        int gap_left;
        bit present;
        level    = int'($urandom_range(65535)) - 32768;
        gap_left = 0;
        for (int j = 0; j < len; j++)
        begin
            if (gap_left == 0 && $urandom_range(29) == 0)
                gap_left = $urandom_range(1, 6);
            if (gap_left > 0)
            begin
                present = 1'b0;
                gap_left--;
            end
            else
                present = ($urandom_range(99) >= miss_pct);
            if ($urandom_range(19) == 0)
                level = int'($urandom_range(65535)) - 32768;
            else
                level = level + int'($urandom_range(12000)) - 6000;
            if (level > 32767)
                level = 32767;
            if (level < -32768)
                level = -32768;
            push_sample(present ? 16'(level) : 16'($urandom), present, j == len - 1);
        end
    endtask

    task automatic add_noise(input int len);
        for (int j = 0; j < len; j++)
            push_sample(16'($urandom), 1'($urandom), $urandom_range(39) == 0);
    endtask

    task automatic set_reg(input hed_reg_index_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_LAG_STEPS:         lag_reg     = val[4:0];
            REG_UP_THRESHOLD:      up_reg      = val;
            REG_DOWN_THRESHOLD:    down_reg    = val;
            REG_DELTA_THRESHOLD:   delta_reg   = val;
            REG_MIN_LENGTH:        min_len_reg = val;
            REG_MISSING_ALLOWANCE: allow_reg   = val;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input int lag, input int up, input int down,
                                  input int delta, input int min_len, input int allow);
        set_reg(REG_LAG_STEPS, 16'(lag));
        set_reg(REG_UP_THRESHOLD, 16'(up));
        set_reg(REG_DOWN_THRESHOLD, 16'(down));
        set_reg(REG_DELTA_THRESHOLD, 16'(delta));
        set_reg(REG_MIN_LENGTH, 16'(min_len));
        set_reg(REG_MISSING_ALLOWANCE, 16'(allow));
        settings_used++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid || episode_q.size() != 0);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    task automatic fill_phase(input int target);
        int added;
        int len;
        added = 0;
        while (added < target)
        begin
            if ($urandom_range(4) == 0)
            begin
                len = $urandom_range(1, 10);
                add_noise(len);
            end
            else
            begin
                len = $urandom_range(4, 40);
                add_sequence(len, $urandom_range(0, 25));
            end
            added += len;
        end
    endtask

    initial
    begin
        int up;
        int down;
        int wait_cyc;

        lag_reg     = 5'(RST_LAG_STEPS);
        up_reg      = 16'(RST_UP_THRESHOLD);
        down_reg    = 16'(RST_DOWN_THRESHOLD);
        delta_reg   = 16'(RST_DELTA_THRESHOLD);
        min_len_reg = 16'(RST_MIN_LENGTH);
        allow_reg   = 16'(RST_MISSING_ALLOWANCE);
        clear_sequence();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Rise on the up level, fall on a negative difference, missing run ends.
        push_sample(16'sd16384, 1'b1, 1'b0);
        push_sample(16'sd12000, 1'b1, 1'b0);
        push_sample(16'sd30000, 1'b1, 1'b0);
        push_sample(16'sd29000, 1'b1, 1'b0);
        push_sample(16'h7e5a,   1'b0, 1'b0);
        // Down level exactly, difference exactly at the threshold, full-scale swings.
        push_sample(16'sd8192,  1'b1, 1'b0);
        push_sample(16'sd12288, 1'b1, 1'b0);
        push_sample(16'sd32767, 1'b1, 1'b0);
        push_sample(-16'sd32768, 1'b1, 1'b0);
        push_sample(-16'sd32768, 1'b1, 1'b0);
        push_sample(16'sd32767, 1'b1, 1'b0);
        push_sample(16'sd32767, 1'b1, 1'b1);
        // Missing final sample ends the episode before the sequence end does.
        push_sample(16'sd20000, 1'b1, 1'b0);
        push_sample(16'h8001,   1'b0, 1'b1);
        push_sample(16'sd20000, 1'b1, 1'b0);
        push_sample(16'sd20000, 1'b1, 1'b1);
        push_sample(16'h5a5a,   1'b0, 1'b1);
        // Explicit end on the final sample gives a single record.
        push_sample(16'sd20000, 1'b1, 1'b0);
        push_sample(16'sd0,     1'b1, 1'b1);
        push_sample(16'hffff,   1'b0, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                0: ;
                1: apply_settings(0, -32768, 32767, 0, 0, 65535);
                2: apply_settings(16, 32767, -32768, 65535, 65535, 0);
                3: apply_settings(31, 20000, -20000, 0, 1, 3);
                4: apply_settings(20, 10000, 0, 3000, 3, 2);
                default:
                begin
                    up   = int'($urandom_range(40000)) - 16000;
                    down = up - int'($urandom_range(20000));
                    if (down < -32768)
                        down = -32768;
                    apply_settings(($urandom_range(9) == 0) ? $urandom_range(17, 31)
                                                            : $urandom_range(0, 16),
                                   up, down, $urandom_range(16000),
                                   $urandom_range(6), $urandom_range(4));
                end
            endcase
            no_gaps = (p == 3);
            if (p == 5)
            begin
                fill_phase(PHASE_ITEMS / 2);
                wait_drained();
                fill_phase(PHASE_ITEMS / 2);
            end
            else
                fill_phase(PHASE_ITEMS);
        end

        do
            @(negedge clk);
        while (sample_q.size() != 0 || s_tvalid);
        wait_cyc = 0;
        while (episode_q.size() != 0 && wait_cyc < DRAIN_LIMIT)
        begin
            @(negedge clk);
            wait_cyc++;
        end
        repeat (10) @(negedge clk);

        if (episode_q.size() != 0)
        begin
            $display("%0t: %0d expected records never arrived, oldest start=%0d end=%0d",
                     $time, episode_q.size(), episode_q[0].ep_start, episode_q[0].ep_end);
            mismatch_count += episode_q.size();
        end

        $display("Sent %0d samples under %0d register settings, lag 0 and zero thresholds too.",
                 samples_sent, settings_used);
        $display("Checked %0d records: %0d explicit end, %0d missing run, %0d sequence end.",
                 records_checked, cause_count[0], cause_count[1], cause_count[2]);
        if (mismatch_count == 0)
            $display("[hysteresis_episode_detector_unit] OK");
        else
            $display("[hysteresis_episode_detector_unit] ERROR");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("[hysteresis_episode_detector_unit] ERROR");
        $finish;
    end

endmodule
